>>> sv/u8cjk_pkg.sv
// ----------------------------------------------------------------------------
// u8cjk_pkg
// Shared constants and the code point range classifier for the UTF-8 CJK
// detector.
// ----------------------------------------------------------------------------
package u8cjk_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CodeW    = 21;
  localparam int unsigned PendingW = 2;
  localparam int unsigned NumRng   = 8;

  typedef logic [CodeW-1:0] code_t;

  // low and high bounds of the matched ranges
  localparam code_t RngLo [NumRng] = '{
    21'h003400, 21'h00F900, 21'h020000, 21'h003000,
    21'h00FF00, 21'h001100, 21'h003130, 21'h00AC00
  };
  localparam code_t RngHi [NumRng] = '{
    21'h009FFF, 21'h00FAFF, 21'h02EBEF, 21'h00303F,
    21'h00FFEF, 21'h0011FF, 21'h00318F, 21'h00D7AF
  };

  // continuation bytes still expected after each lead class
  localparam logic [PendingW-1:0] Pend2Byte = 2'd1;
  localparam logic [PendingW-1:0] Pend3Byte = 2'd2;
  localparam logic [PendingW-1:0] Pend4Byte = 2'd3;

  function automatic logic is_cjk(code_t c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumRng; i++) begin
      hit = hit | ((c >= RngLo[i]) && (c <= RngHi[i]));
    end
    return hit;
  endfunction

endpackage

>>> sv/utf8_cjk_detector_top.sv
// ----------------------------------------------------------------------------
// utf8_cjk_detector_top
// UTF-8 decoder with a CJK / Hangul / full-width code point classifier.
// ----------------------------------------------------------------------------
// Takes one string byte per transfer and returns one result per byte. A byte
// is captured in an input register, decoded against the running sequence
// state by a single level of shallow logic and placed in a result register,
// so the block sustains one byte per cycle; it stalls only when the result
// register is full and not taken. Decoding state (pending continuation count,
// partial code point, sticky match flag, stop flag) is cleared after each
// final byte.
module utf8_cjk_detector_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [u8cjk_pkg::ByteW-1:0]   text_byte_i,
  input  logic                          final_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          code_done_o,
  output logic [u8cjk_pkg::CodeW-1:0]   code_point_o,
  output logic                          point_is_cjk_o,
  output logic                          string_has_cjk_o,
  output logic                          malformed_o,
  output logic                          end_of_string_o
);

  // input register
  logic                          s1_valid_q;
  logic [u8cjk_pkg::ByteW-1:0]   s1_byte_q;
  logic                          s1_final_q;
  logic                          s1_fire;

  // decode state
  logic [u8cjk_pkg::PendingW-1:0] pending_q, pending_d;
  u8cjk_pkg::code_t               partial_q, partial_d;
  logic                           cjk_seen_q, cjk_seen_d;
  logic                           stopped_q, stopped_d;

  // result register
  logic             out_valid_q;
  logic             done_q, done_d;
  u8cjk_pkg::code_t code_q, code_d;
  logic             hit_q, hit_d;
  logic             has_cjk_q, has_cjk_d;
  logic             malformed_q, malformed_d;
  logic             eos_q;

  logic s1_advance;

  assign s1_advance = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_advance;
  assign in_ready_o = !s1_valid_q || s1_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q  <= text_byte_i;
      s1_final_q <= final_byte_i;
    end
  end

  // decode step
  always_comb begin
    logic [u8cjk_pkg::ByteW-1:0] b;
    logic                        cp_done;
    u8cjk_pkg::code_t            cp;
    logic [u8cjk_pkg::PendingW-1:0] pend;
    u8cjk_pkg::code_t            part;
    logic                        stop;
    logic                        hit;

    b       = s1_byte_q;
    cp_done = 1'b0;
    cp      = '0;
    pend    = pending_q;
    part    = partial_q;
    stop    = stopped_q;
    hit     = 1'b0;

    if (!stopped_q) begin
      if (pending_q != '0) begin
        if (b[7:6] == 2'b10) begin
          part = {partial_q[u8cjk_pkg::CodeW-7:0], b[5:0]};
          pend = pending_q - 2'd1;
          if (pend == '0) begin
            cp_done = 1'b1;
            cp      = part;
            part    = '0;
          end
        end else begin
          stop = 1'b1;
          pend = '0;
          part = '0;
        end
      end else if (b[7] == 1'b0) begin
        cp_done = 1'b1;
        cp      = {{(u8cjk_pkg::CodeW-u8cjk_pkg::ByteW){1'b0}}, b};
      end else if (b[7:5] == 3'b110) begin
        part = {{(u8cjk_pkg::CodeW-5){1'b0}}, b[4:0]};
        pend = u8cjk_pkg::Pend2Byte;
      end else if (b[7:4] == 4'b1110) begin
        part = {{(u8cjk_pkg::CodeW-4){1'b0}}, b[3:0]};
        pend = u8cjk_pkg::Pend3Byte;
      end else if (b[7:3] == 5'b11110) begin
        part = {{(u8cjk_pkg::CodeW-3){1'b0}}, b[2:0]};
        pend = u8cjk_pkg::Pend4Byte;
      end else begin
        cp_done = 1'b1;
      end

      if (s1_final_q && (pend != '0)) begin
        stop = 1'b1;
        pend = '0;
        part = '0;
      end
    end

    if (cp_done) begin
      hit = u8cjk_pkg::is_cjk(cp);
    end

    done_d      = cp_done;
    code_d      = cp;
    hit_d       = hit;
    has_cjk_d   = cjk_seen_q | hit;
    malformed_d = stop;

    if (s1_final_q) begin
      pending_d  = '0;
      partial_d  = '0;
      cjk_seen_d = 1'b0;
      stopped_d  = 1'b0;
    end else begin
      pending_d  = pend;
      partial_d  = part;
      cjk_seen_d = has_cjk_d;
      stopped_d  = stop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= '0;
      partial_q  <= '0;
      cjk_seen_q <= 1'b0;
      stopped_q  <= 1'b0;
    end else if (s1_fire) begin
      pending_q  <= pending_d;
      partial_q  <= partial_d;
      cjk_seen_q <= cjk_seen_d;
      stopped_q  <= stopped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      done_q      <= done_d;
      code_q      <= code_d;
      hit_q       <= hit_d;
      has_cjk_q   <= has_cjk_d;
      malformed_q <= malformed_d;
      eos_q       <= s1_final_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_done_o      = done_q;
  assign code_point_o     = code_q;
  assign point_is_cjk_o   = hit_q;
  assign string_has_cjk_o = has_cjk_q;
  assign malformed_o      = malformed_q;
  assign end_of_string_o  = eos_q;

  // a stopped string completes no code point
  a_stop_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && malformed_o) |-> !code_done_o)
    else $error("malformed result carries a completed code point");

  // a match is always a completed code point and sets the sticky flag
  a_hit_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && point_is_cjk_o) |-> (code_done_o && string_has_cjk_o))
    else $error("match without completion or sticky flag");

  // decode state is clear after a final byte
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_final_q) |=> (pending_q == '0 && !cjk_seen_q && !stopped_q))
    else $error("decode state not cleared after end of string");

  // a result that is not taken must stay valid and unchanged
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(code_point_o)))
    else $error("pending result overwritten");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UTF-8 decoder with CJK range classifier.
// ----------------------------------------------------------------------------
// Strings are fed one byte per transfer and every result is checked against
// a predictor of the decode and classify logic. The tests are a short
// directed set first, then random strings under several idle and stall
// mixes. They end with a long output hold-off that fills the block, and a
// sender that pauses until all results are drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReports  = 10;

  localparam logic [u8cjk_pkg::CodeW-1:0] RangeBound [16] = '{
    21'h003400, 21'h009FFF, 21'h00F900, 21'h00FAFF,
    21'h020000, 21'h02EBEF, 21'h003000, 21'h00303F,
    21'h00FF00, 21'h00FFEF, 21'h001100, 21'h0011FF,
    21'h003130, 21'h00318F, 21'h00AC00, 21'h00D7AF
  };

  typedef struct packed {
    logic             done;
    u8cjk_pkg::code_t cp;
    logic             hit;
    logic             has;
    logic             bad;
    logic             eos;
  } decode_result_t;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic [u8cjk_pkg::ByteW-1:0]  text_byte_i  = 8'h01;
  logic                         final_byte_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic                         code_done_o;
  u8cjk_pkg::code_t             code_point_o;
  logic                         point_is_cjk_o;
  logic                         string_has_cjk_o;
  logic                         malformed_o;
  logic                         end_of_string_o;

  // predictor state
  logic [u8cjk_pkg::PendingW-1:0] dec_pending = '0;
  u8cjk_pkg::code_t               dec_partial = '0;
  logic                           dec_seen    = 1'b0;
  logic                           dec_stopped = 1'b0;

  decode_result_t decoded_q [$];
  logic [7:0]     str_q [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req_cnt   = 0;
  int unsigned hold_seen_cnt  = 0;
  int unsigned hold_left      = 0;
  int unsigned fail_cnt       = 0;
  int unsigned cycle_cnt      = 0;

  utf8_cjk_detector_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .final_byte_i     (final_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_done_o      (code_done_o),
    .code_point_o     (code_point_o),
    .point_is_cjk_o   (point_is_cjk_o),
    .string_has_cjk_o (string_has_cjk_o),
    .malformed_o      (malformed_o),
    .end_of_string_o  (end_of_string_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic in_cjk_range(u8cjk_pkg::code_t c);
    return ((c >= 21'h003400) && (c <= 21'h009FFF)) ||
           ((c >= 21'h00F900) && (c <= 21'h00FAFF)) ||
           ((c >= 21'h020000) && (c <= 21'h02EBEF)) ||
           ((c >= 21'h003000) && (c <= 21'h00303F)) ||
           ((c >= 21'h00FF00) && (c <= 21'h00FFEF)) ||
           ((c >= 21'h001100) && (c <= 21'h0011FF)) ||
           ((c >= 21'h003130) && (c <= 21'h00318F)) ||
           ((c >= 21'h00AC00) && (c <= 21'h00D7AF));
  endfunction

  function automatic decode_result_t decode_next_byte(logic [7:0] b, logic fin);
    decode_result_t r;
    r = '0;
    if (!dec_stopped) begin
      if (dec_pending != '0) begin
        if (b[7:6] == 2'b10) begin
          dec_partial = {dec_partial[14:0], b[5:0]};
          dec_pending = dec_pending - 2'd1;
          if (dec_pending == '0) begin
            r.done      = 1'b1;
            r.cp        = dec_partial;
            dec_partial = '0;
          end
        end else begin
          dec_stopped = 1'b1;
          dec_pending = '0;
          dec_partial = '0;
        end
      end else if (!b[7]) begin
        r.done = 1'b1;
        r.cp   = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        dec_partial = {16'd0, b[4:0]};
        dec_pending = u8cjk_pkg::Pend2Byte;
      end else if (b[7:4] == 4'b1110) begin
        dec_partial = {17'd0, b[3:0]};
        dec_pending = u8cjk_pkg::Pend3Byte;
      end else if (b[7:3] == 5'b11110) begin
        dec_partial = {18'd0, b[2:0]};
        dec_pending = u8cjk_pkg::Pend4Byte;
      end else begin
        // unmatched lead gives code point zero
        r.done = 1'b1;
        r.cp   = '0;
      end
      if (fin && (dec_pending != '0)) begin
        dec_stopped = 1'b1;
        dec_pending = '0;
        dec_partial = '0;
      end
    end
    if (r.done) begin
      r.hit    = in_cjk_range(r.cp);
      dec_seen = dec_seen | r.hit;
    end
    r.has = dec_seen;
    r.bad = dec_stopped;
    r.eos = fin;
    if (fin) begin
      dec_pending = '0;
      dec_partial = '0;
      dec_seen    = 1'b0;
      dec_stopped = 1'b0;
    end
    return r;
  endfunction

  // receiver: stalls, long hold-off and result check
  initial begin
    decode_result_t exp_r;
    decode_result_t got_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got_r = '{code_done_o, code_point_o, point_is_cjk_o, string_has_cjk_o,
                  malformed_o, end_of_string_o};
        if (decoded_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports) begin
            $display("unexpected result: done=%0b cp=%06h hit=%0b has=%0b bad=%0b eos=%0b",
                     got_r.done, got_r.cp, got_r.hit, got_r.has, got_r.bad, got_r.eos);
          end
        end else begin
          exp_r = decoded_q.pop_front();
          if ((got_r.done !== exp_r.done) || (got_r.cp !== exp_r.cp) ||
              (got_r.hit !== exp_r.hit) || (got_r.has !== exp_r.has) ||
              (got_r.bad !== exp_r.bad) || (got_r.eos !== exp_r.eos)) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports) begin
              $display("mismatch exp: done=%0b cp=%06h hit=%0b has=%0b bad=%0b eos=%0b",
                       exp_r.done, exp_r.cp, exp_r.hit, exp_r.has, exp_r.bad, exp_r.eos);
              $display("         got: done=%0b cp=%06h hit=%0b has=%0b bad=%0b eos=%0b",
                       got_r.done, got_r.cp, got_r.hit, got_r.has, got_r.bad, got_r.eos);
            end
          end
        end
      end
      if (hold_seen_cnt != hold_req_cnt) begin
        hold_seen_cnt = hold_req_cnt;
        hold_left     = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    decoded_q.push_back(decode_next_byte(b, fin));
  endtask

  task automatic send_string(inout int unsigned sent);
    for (int i = 0; i < str_q.size(); i++) begin
      send_byte(str_q[i], i == (str_q.size() - 1));
    end
    sent += str_q.size();
    str_q.delete();
  endtask

  task automatic append_code(input u8cjk_pkg::code_t c, input int nb);
    case (nb)
      1: begin
        str_q.push_back({1'b0, c[6:0]});
      end
      2: begin
        str_q.push_back({3'b110, c[10:6]});
        str_q.push_back({2'b10, c[5:0]});
      end
      3: begin
        str_q.push_back({4'b1110, c[15:12]});
        str_q.push_back({2'b10, c[11:6]});
        str_q.push_back({2'b10, c[5:0]});
      end
      default: begin
        str_q.push_back({5'b11110, c[20:18]});
        str_q.push_back({2'b10, c[17:12]});
        str_q.push_back({2'b10, c[11:6]});
        str_q.push_back({2'b10, c[5:0]});
      end
    endcase
  endtask

  // mostly well-formed sequences, some noise, bad continuations and cut-offs
  task automatic build_random_string();
    int               n_pts;
    int               sel;
    int               nb;
    int               ncont;
    u8cjk_pkg::code_t c;
    n_pts = $urandom_range(1, 8);
    for (int k = 0; k < n_pts; k++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        c  = RangeBound[$urandom_range(15)] + u8cjk_pkg::code_t'($urandom_range(4))
             - u8cjk_pkg::code_t'(2);
        nb = (c < 21'h800) ? 2 : (c < 21'h10000) ? 3 : 4;
        if ((nb < 4) && ($urandom_range(9) == 0)) nb++;
        append_code(c, nb);
      end else if (sel < 80) begin
        nb = $urandom_range(1, 4);
        case (nb)
          1:       c = u8cjk_pkg::code_t'($urandom_range(1, 8'h7F));
          2:       c = u8cjk_pkg::code_t'($urandom_range(0, 16'h07FF));
          3:       c = u8cjk_pkg::code_t'($urandom_range(0, 16'hFFFF));
          default: c = u8cjk_pkg::code_t'($urandom_range(0, 21'h1FFFFF));
        endcase
        append_code(c, nb);
      end else if (sel < 88) begin
        str_q.push_back($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                          : 8'($urandom_range(8'hF8, 8'hFF)));
      end else if (sel < 94) begin
        append_code(u8cjk_pkg::code_t'($urandom_range(0, 21'h1FFFFF)),
                    $urandom_range(2, 4));
        void'(str_q.pop_back());
        str_q.push_back($urandom_range(1) ? 8'($urandom_range(1, 8'h7F))
                                          : 8'($urandom_range(8'hC0, 8'hFF)));
      end else begin
        str_q.push_back(8'($urandom_range(1, 8'hFF)));
      end
    end
    if ($urandom_range(9) == 0) begin
      nb    = $urandom_range(2, 4);
      ncont = $urandom_range(0, nb - 2);
      append_code(u8cjk_pkg::code_t'($urandom_range(0, 21'h1FFFFF)), nb);
      for (int i = 0; i < nb - 1 - ncont; i++) void'(str_q.pop_back());
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int unsigned sent;
    sent = 0;
    // ascii extremes, two, three and four byte forms, unmatched leads
    str_q = '{8'h01, 8'h7F, 8'hC3, 8'hA9, 8'hE4, 8'hB8, 8'hAD, 8'h80, 8'hFF};
    send_string(sent);
    str_q = '{8'hF0, 8'hA0, 8'h80, 8'h80, 8'hF8, 8'hBF, 8'hEA, 8'hB0, 8'h80};
    send_string(sent);
    // bad continuation, later bytes stay stopped
    str_q = '{8'hE4, 8'h41, 8'h42};
    send_string(sent);
    // sequence cut off by the final byte
    str_q = '{8'hE4, 8'hB8};
    send_string(sent);
    // largest code point
    str_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
    send_string(sent);
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_bytes);
    int unsigned sent;
    sent           = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_bytes) begin
      build_random_string();
      send_string(sent);
    end
  endtask

  task automatic test_output_hold();
    int unsigned sent;
    sent           = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req_cnt++;
    while (sent < 40) begin
      build_random_string();
      send_string(sent);
    end
  endtask

  task automatic test_drain_pause();
    int unsigned sent;
    sent           = 0;
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    while (sent < 30) begin
      build_random_string();
      send_string(sent);
      wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(0, 0, 110);
    test_random_phase(46, 0, 110);
    test_random_phase(0, 46, 110);
    test_random_phase(17, 17, 110);
    test_output_hold();
    test_drain_pause();

    recv_stall_pct = 0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if ((fail_cnt == 0) && (decoded_q.size() == 0)) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
